@@ rtl/ipwc_pkg.sv @@
package ipwc_pkg;

    // Storage and arithmetic limits
    localparam int unsigned MAX_PULSES  = 512;
    localparam int unsigned CNT_W       = 10;
    localparam int unsigned IDX_W       = 9;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned UNIT_W      = 8;
    localparam int unsigned BYTES_W     = 11;
    localparam int unsigned WIN_W       = 16;
    localparam int unsigned TMO_W       = 23;
    localparam int unsigned LIMIT_W     = 33;
    localparam int unsigned WIDTH_W     = 16;
    localparam int unsigned CAUSE_W     = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned US_PER_MS   = 1000;

    // Command codes on the input tuser
    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_EDGE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_TMO = 2'd3;

    // End causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FIRST_HI = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BUF_FULL = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_WINDOW   = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_START_TO = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LIMIT,
        S_CHECK,
        S_RESULT
    } t_state;

    // Request to the serial divider
    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [UNIT_W-1:0]   divisor;
    } t_div_req;

    // Status from the serial divider
    typedef struct packed {
        logic                done;
        logic [TIME_W-1:0]   quot;
    } t_div_rsp;

endpackage

@@ rtl/ipwc_div.sv @@
module ipwc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipwc_pkg::t_div_req i_req,
    output ipwc_pkg::t_div_rsp o_rsp
);
    import ipwc_pkg::*;

    localparam int unsigned STEP_W = $clog2(TIME_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [TIME_W-1:0]   r_quot;
    logic [UNIT_W-1:0]   r_rem;
    logic [UNIT_W-1:0]   r_div;
    logic [UNIT_W:0]     w_trial;
    logic                w_fit;

    // Shift in the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_quot[TIME_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division, quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[TIME_W-2:0], w_fit};
            r_rem  <= w_fit ? UNIT_W'(w_trial - {1'b0, r_div}) : w_trial[UNIT_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ rtl/ir_pulse_width_capture.sv @@
// Arm, first edge and ignored items: the result is valid in the cycle after acceptance.
// Later edges: the result waits for the bit-serial 32-by-8 divider.
// Time ticks: limit multiply, compare, then result.
// One transaction at a time: the next input is taken only once the result leaves.
// Reset (synchronous, active low): idle, no capture, registers at defaults.
module ir_pulse_width_capture (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ipwc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipwc_pkg::TMO_W-1:0]    i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // line_level[0], now_us[32:1]
    input  logic [1:0]                    s_axis_tuser,  // cmd[1:0]
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata   // capturing[0], pulse_valid[1],
                                                         // pulse_index[10:2],
                                                         // pulse_width[26:11],
                                                         // done_res[27],
                                                         // pulse_count[37:28],
                                                         // end_cause[40:38]
);
    import ipwc_pkg::*;

    t_state r_state, n_state;

    // Configuration registers
    logic [UNIT_W-1:0]  r_time_unit;
    logic [BYTES_W-1:0] r_buf_bytes;
    logic [WIN_W-1:0]   r_window;
    logic [TMO_W-1:0]   r_start_tmo;

    // Capture state
    logic               r_active;
    logic [CNT_W-1:0]   r_count;
    logic [TIME_W-1:0]  r_last;
    logic [TIME_W-1:0]  r_arm;
    logic [TIME_W-1:0]  r_first;

    // Working registers
    logic [TIME_W-1:0]  r_elapsed;
    logic [LIMIT_W-1:0] r_limit;

    // Result register
    logic               r_res_capt;
    logic               r_res_pvalid;
    logic [IDX_W-1:0]   r_res_index;
    logic [WIDTH_W-1:0] r_res_width;
    logic               r_res_done;
    logic [CNT_W-1:0]   r_res_count;
    logic [CAUSE_W-1:0] r_res_cause;

    logic               w_in_acc;
    logic               w_out_acc;
    logic [1:0]         w_cmd;
    logic               w_level;
    logic [TIME_W-1:0]  w_now;
    logic               w_div_path;
    logic               w_tick_path;
    logic [BYTES_W-1:0] w_bytes;
    logic [CNT_W-1:0]   w_half;
    logic [CNT_W-1:0]   w_lvl_limit;
    logic [TMO_W-1:0]   w_lim_ms;
    logic [WIDTH_W-1:0] w_sat;
    logic               w_fire;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    assign w_cmd   = s_axis_tuser;
    assign w_level = s_axis_tdata[0];
    assign w_now   = s_axis_tdata[TIME_W:1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_RESULT);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    // Classify the incoming transaction
    assign w_div_path  = (w_cmd == CMD_EDGE) && r_active && (r_count != '0);
    assign w_tick_path = (w_cmd == CMD_TICK) && r_active;

    // Level budget: half the byte budget, at least one, capped at the store size
    assign w_bytes     = (r_buf_bytes < BYTES_W'(2)) ? BYTES_W'(2) : r_buf_bytes;
    assign w_half      = w_bytes[BYTES_W-1:1];
    assign w_lvl_limit = (w_half > CNT_W'(MAX_PULSES)) ? CNT_W'(MAX_PULSES) : w_half;

    // Pick the millisecond limit for the tick check
    assign w_lim_ms = (r_count == '0) ? r_start_tmo : TMO_W'(r_window);

    // Saturate the quotient to the width field
    assign w_sat = (|w_div_rsp.quot[TIME_W-1:WIDTH_W]) ? {WIDTH_W{1'b1}}
                                                       : w_div_rsp.quot[WIDTH_W-1:0];

    // Tick check: strict for the start timeout, inclusive for the window
    assign w_fire = (r_count == '0) ? ({1'b0, r_elapsed} > r_limit)
                                    : ({1'b0, r_elapsed} >= r_limit);

    // Kick the divider with the time since the last edge
    assign w_div_req.start    = w_in_acc && w_div_path;
    assign w_div_req.dividend = w_now - r_last;
    assign w_div_req.divisor  = (r_time_unit == '0) ? UNIT_W'(1) : r_time_unit;

    ipwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority if (w_div_path) begin
                        n_state = S_DIV;
                    end else if (w_tick_path) begin
                        n_state = S_LIMIT;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_RESULT;
                end
            end
            S_LIMIT: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_unit <= UNIT_W'(1);
            r_buf_bytes <= BYTES_W'(1024);
            r_window    <= WIN_W'(200);
            r_start_tmo <= TMO_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIME_UNIT: r_time_unit <= i_cfg_data[UNIT_W-1:0];
                REG_BUF_BYTES: r_buf_bytes <= i_cfg_data[BYTES_W-1:0];
                REG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                REG_START_TMO: r_start_tmo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_last   <= '0;
            r_arm    <= '0;
            r_first  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        priority if (w_cmd == CMD_ARM) begin
                            // arm or restart
                            r_active <= 1'b1;
                            r_count  <= '0;
                            r_last   <= '0;
                            r_first  <= '0;
                            r_arm    <= w_now;
                        end else if ((w_cmd == CMD_EDGE) && r_active && (r_count == '0)) begin
                            // first edge must leave the line low
                            if (w_level) begin
                                r_active <= 1'b0;
                            end else begin
                                r_first <= w_now;
                                r_last  <= w_now;
                                r_count <= CNT_W'(1);
                            end
                        end else if (w_div_path) begin
                            r_last <= w_now;
                        end else begin
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_count <= r_count + 1'b1;
                        if (r_count >= w_lvl_limit) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_fire) begin
                        r_active <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Tick working registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_acc) begin
            r_elapsed <= w_now - ((r_count == '0) ? r_arm : r_first);
        end
        if (r_state == S_LIMIT) begin
            r_limit <= LIMIT_W'(w_lim_ms) * LIMIT_W'(US_PER_MS);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_res_capt   <= r_active;
                    r_res_pvalid <= 1'b0;
                    r_res_index  <= '0;
                    r_res_width  <= '0;
                    r_res_done   <= 1'b0;
                    r_res_count  <= '0;
                    r_res_cause  <= CAUSE_NONE;
                    priority if (w_cmd == CMD_ARM) begin
                        r_res_capt <= 1'b1;
                    end else if ((w_cmd == CMD_EDGE) && r_active && (r_count == '0)
                                 && w_level) begin
                        r_res_capt  <= 1'b0;
                        r_res_done  <= 1'b1;
                        r_res_cause <= CAUSE_FIRST_HI;
                    end else begin
                    end
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_res_pvalid <= 1'b1;
                    r_res_index  <= IDX_W'(r_count - 1'b1);
                    r_res_width  <= w_sat;
                    if (r_count >= w_lvl_limit) begin
                        r_res_capt  <= 1'b0;
                        r_res_done  <= 1'b1;
                        r_res_count <= r_count;
                        r_res_cause <= CAUSE_BUF_FULL;
                    end else begin
                        r_res_capt <= 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (w_fire) begin
                    r_res_capt <= 1'b0;
                    r_res_done <= 1'b1;
                    if (r_count == '0) begin
                        r_res_count <= '0;
                        r_res_cause <= CAUSE_START_TO;
                    end else begin
                        r_res_count <= r_count - 1'b1;
                        r_res_cause <= CAUSE_WINDOW;
                    end
                end else begin
                    r_res_capt <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Pack the result
    assign m_axis_tdata = {7'd0, r_res_cause, r_res_count, r_res_done, r_res_width,
                           r_res_index, r_res_pvalid, r_res_capt};

endmodule
